// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = 6;

  localparam logic [WordW-1:0] Prime  = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [WordW-1:0] One    = 64'd1;
  localparam logic [CntW-1:0]  CntMax = 6'd63;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START_SQ,
    S_WAIT_SQ,
    S_START_MUL,
    S_WAIT_MUL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mm_req_t;

endpackage

`default_nettype wire

// File: rtl/mexp_if.sv
`default_nettype none

interface mexp_in_if;
  import mexp_pkg::*;

  logic  valid;
  logic  ready;
  word_t base;
  word_t exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic  valid;
  logic  ready;
  word_t power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

// File: rtl/mexp_modmul.sv
`default_nettype none

module mexp_modmul (
  input  wire                 clk,
  input  wire                 rst,
  input  mexp_pkg::mm_req_t   req,
  output logic                done,
  output mexp_pkg::word_t     prod
);
  import mexp_pkg::*;

  `include "assert_macros.svh"

  logic  busy;
  word_t acc;
  word_t add;
  word_t y;

  word_t gap;
  word_t acc_next;
  word_t dbl;
  word_t add_next;

  always_comb begin
    gap      = Prime - add;
    acc_next = acc;
    if (y[0]) begin
      acc_next = (acc >= gap) ? (acc - gap) : (acc + add);
    end
    dbl      = add + add;
    add_next = (add >= gap) ? (dbl - Prime) : dbl;
  end

  assign done = busy && (y == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      add <= req.x;
      y   <= req.y;
    end else if (busy && !done) begin
      acc <= acc_next;
      add <= add_next;
      y   <= {1'b0, y[WordW-1:1]};
    end
  end

  `ASSERT_SAME(a_acc_reduced, clk, rst, busy, acc < Prime, "accumulator left the residue range")
  `ASSERT_SAME(a_add_reduced, clk, rst, busy, add < Prime, "addend left the residue range")
  `ASSERT_SAME(a_no_restart, clk, rst, req.start, !busy, "multiply started while busy")

endmodule

`default_nettype wire

// File: rtl/mod_exp_64.sv
// each transaction takes 64 squarings and one multiply per set exponent bit,
//   all on a single shared bit-serial modular multiplier; a new transaction is
//   accepted only after the previous one has finished
// input ready only while idle; a finished result waits in the output register
// reset: synchronous, active high; clears the sequencer and output valid
`default_nettype none

module mod_exp_64 (
  input  wire        clk,
  input  wire        rst,
  mexp_in_if.sink    operands,
  mexp_out_if.source result
);
  import mexp_pkg::*;

  `include "assert_macros.svh"

  state_t          state;
  state_t          state_next;
  word_t           b;
  word_t           e;
  word_t           r;
  logic [CntW-1:0] cnt;
  logic            out_valid;
  word_t           out_data;

  mm_req_t mm_req;
  logic    mm_done;
  word_t   mm_prod;
  logic    advance;
  logic    load_out;

  mexp_modmul u_modmul (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_req),
    .done (mm_done),
    .prod (mm_prod)
  );

  assign operands.ready   = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.power_mod = out_data;

  always_comb begin
    state_next   = state;
    mm_req.start = 1'b0;
    mm_req.x     = r;
    mm_req.y     = r;
    advance      = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (operands.valid) begin
          state_next = S_START_SQ;
        end
      end
      S_START_SQ: begin
        mm_req.start = 1'b1;
        state_next   = S_WAIT_SQ;
      end
      S_WAIT_SQ: begin
        if (mm_done) begin
          if (e[WordW-1]) begin
            state_next = S_START_MUL;
          end else begin
            advance    = 1'b1;
            state_next = (cnt == '0) ? S_FINISH : S_START_SQ;
          end
        end
      end
      S_START_MUL: begin
        mm_req.start = 1'b1;
        mm_req.y     = b;
        state_next   = S_WAIT_MUL;
      end
      S_WAIT_MUL: begin
        if (mm_done) begin
          advance    = 1'b1;
          state_next = (cnt == '0) ? S_FINISH : S_START_SQ;
        end
      end
      S_FINISH: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && operands.valid) begin
      b   <= (operands.base >= Prime) ? (operands.base - Prime) : operands.base;
      e   <= operands.exponent;
      r   <= One;
      cnt <= CntMax;
    end else begin
      if ((state == S_WAIT_SQ || state == S_WAIT_MUL) && mm_done) begin
        r <= mm_prod;
      end
      if (advance) begin
        e   <= {e[WordW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= r;
    end
  end

  `ASSERT_SAME(a_r_reduced, clk, rst, state != S_IDLE, r < Prime, "running power out of range")
  `ASSERT_SAME(a_done_waiting, clk, rst, mm_done, state == S_WAIT_SQ || state == S_WAIT_MUL, "multiply finished outside a wait state")
  `ASSERT_NEXT(a_accept_load, clk, rst, state == S_IDLE && operands.valid, state == S_START_SQ && cnt == CntMax, "accepted transaction not loaded")

endmodule

`default_nettype wire
